[rtl/pts_pkg.sv]
// Shared types and constants of the pan/tilt servo tracker.
package pts_pkg;

  typedef enum logic [2:0] {
    KIND_POS    = 3'd0,
    KIND_SPEED  = 3'd1,
    KIND_ACCEL  = 3'd2,
    KIND_QUERY  = 3'd3,
    KIND_TOGGLE = 3'd4,
    KIND_ACK    = 3'd5,
    KIND_EVENT  = 3'd6
  } kind_t;

  localparam logic       FUNC_EVENT  = 1'b1;
  localparam logic [7:0] CMD_POS     = 8'd0;
  localparam logic [7:0] CMD_SPEED   = 8'd1;
  localparam logic [7:0] CMD_ACCEL   = 8'd2;
  localparam logic [7:0] CMD_QUERY   = 8'd3;
  localparam logic [7:0] CMD_TOGGLE  = 8'd4;

  localparam logic [7:0] OP_MULTI    = 8'h9F;
  localparam logic [7:0] OP_SPEED    = 8'h87;
  localparam logic [7:0] OP_ACCEL    = 8'h89;
  localparam logic [7:0] OP_QUERY    = 8'h90;
  localparam logic [7:0] MULTI_COUNT = 8'd2;

  localparam logic PORT_SERVO = 1'b0;
  localparam logic PORT_HOST  = 1'b1;

  localparam logic [2:0] REG_PAN_MIN       = 3'd0;
  localparam logic [2:0] REG_PAN_MAX       = 3'd1;
  localparam logic [2:0] REG_TILT_MIN      = 3'd2;
  localparam logic [2:0] REG_TILT_MAX      = 3'd3;
  localparam logic [2:0] REG_CENTER_X      = 3'd4;
  localparam logic [2:0] REG_CENTER_Y      = 3'd5;
  localparam logic [2:0] REG_FIRST_CHANNEL = 3'd6;

  localparam logic [15:0] PAN_MIN_RESET   = 16'd3696;
  localparam logic [15:0] PAN_MAX_RESET   = 16'd7232;
  localparam logic [15:0] TILT_MIN_RESET  = 16'd3640;
  localparam logic [15:0] TILT_MAX_RESET  = 16'd7200;
  localparam logic [11:0] CENTER_X_RESET  = 12'd640;
  localparam logic [11:0] CENTER_Y_RESET  = 12'd360;
  localparam logic [6:0]  CHANNEL_RESET   = 7'd10;
  localparam logic [15:0] POS_RESET       = 16'd6000;

  // gains 175/576 and 125/324; 576 = 64*9, 324 = 4*81
  localparam logic [7:0]  PAN_NUM    = 8'd175;
  localparam logic [7:0]  TILT_NUM   = 8'd125;
  localparam logic [16:0] PAN_RECIP  = 17'd116509;   // ceil(2^20 / 9)
  localparam logic [20:0] TILT_RECIP = 21'd1657009;  // ceil(2^27 / 81)

  typedef struct packed {
    logic [15:0] pan_min;
    logic [15:0] pan_max;
    logic [15:0] tilt_min;
    logic [15:0] tilt_max;
    logic [11:0] center_x;
    logic [11:0] center_y;
    logic [6:0]  first_channel;
  } cfg_t;

  // pan_f / tilt_f: floor of the scaled offset; *_inex: division not exact
  typedef struct packed {
    kind_t              kind;
    logic [15:0]        v1;
    logic [15:0]        v2;
    logic signed [15:0] pan_f;
    logic               pan_inex;
    logic signed [15:0] tilt_f;
    logic               tilt_inex;
  } entry_t;

  function automatic logic [7:0] ack_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = 8'h57;
      3'd1:    b = 8'h6F;
      3'd2:    b = 8'h72;
      3'd3:    b = 8'h6B;
      3'd4:    b = 8'h73;
      3'd5:    b = 8'h0A;
      default: b = 8'h0D;
    endcase
    return b;
  endfunction

endpackage

[rtl/pts_front.sv]
// Front end: takes input beats, classifies them, scales target offsets.
module pts_front (
  input  logic               clk,
  input  logic               rst,
  input  pts_pkg::cfg_t      cfg,
  input  logic               push,
  output logic               full,
  input  logic               func,
  input  logic [7:0]         command_code,
  input  logic [15:0]        first_value,
  input  logic [15:0]        second_value,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  output logic               q_push,
  output pts_pkg::entry_t    q_data,
  input  logic               q_full
);

  logic adv1, adv2, adv3, take;
  logic s1_valid, s2_valid, s3_valid;

  pts_pkg::kind_t     kind_in;
  logic signed [16:0] dx_in, dy_in;

  pts_pkg::kind_t     s1_kind, s2_kind, s3_kind;
  logic [15:0]        s1_v1, s1_v2, s2_v1, s2_v2, s3_v1, s3_v2;
  logic signed [16:0] s1_dx, s1_dy;

  logic [15:0] pabs, tabs;
  logic [23:0] pprod, tprod;
  logic        s2_pneg, s2_tneg;
  logic [22:0] s2_pmag, s2_tmag;

  logic [33:0] pq_prod;
  logic [41:0] tq_prod;
  logic        s3_pneg, s3_tneg, s3_plow, s3_tlow;
  logic [13:0] s3_pq, s3_tq;
  logic [16:0] s3_pn;
  logic [20:0] s3_tn;

  logic [16:0] pq_x9;
  logic [20:0] tq_x81;
  logic        pinex, tinex;
  logic [15:0] pq_up, tq_up;

  assign adv3   = !s3_valid || !q_full;
  assign adv2   = !s2_valid || adv3;
  assign adv1   = !s1_valid || adv2;
  assign full   = !adv1;
  assign take   = push && adv1;
  assign q_push = s3_valid && !q_full;

  always_comb begin
    if (func == pts_pkg::FUNC_EVENT) begin
      kind_in = pts_pkg::KIND_EVENT;
    end else begin
      unique case (command_code)
        pts_pkg::CMD_POS:    kind_in = pts_pkg::KIND_POS;
        pts_pkg::CMD_SPEED:  kind_in = pts_pkg::KIND_SPEED;
        pts_pkg::CMD_ACCEL:  kind_in = pts_pkg::KIND_ACCEL;
        pts_pkg::CMD_QUERY:  kind_in = pts_pkg::KIND_QUERY;
        pts_pkg::CMD_TOGGLE: kind_in = pts_pkg::KIND_TOGGLE;
        default:             kind_in = pts_pkg::KIND_ACK;
      endcase
    end
    dx_in = $signed({5'd0, cfg.center_x}) - $signed({target_x[15], target_x});
    dy_in = $signed({5'd0, cfg.center_y}) - $signed({target_y[15], target_y});
  end

  always_comb begin
    pabs  = s1_dx[16] ? 16'(-s1_dx) : s1_dx[15:0];
    tabs  = s1_dy[16] ? 16'(-s1_dy) : s1_dy[15:0];
    pprod = {8'd0, pabs} * {16'd0, pts_pkg::PAN_NUM};
    tprod = {8'd0, tabs} * {16'd0, pts_pkg::TILT_NUM};
  end

  always_comb begin
    pq_prod = {17'd0, s2_pmag[22:6]} * {17'd0, pts_pkg::PAN_RECIP};
    tq_prod = {21'd0, s2_tmag[22:2]} * {21'd0, pts_pkg::TILT_RECIP};
  end

  always_comb begin
    pq_x9  = {s3_pq, 3'd0} + {3'd0, s3_pq};
    tq_x81 = {1'b0, s3_tq, 6'd0} + {3'd0, s3_tq, 4'd0} + {7'd0, s3_tq};
    pinex  = s3_plow || (pq_x9 != s3_pn);
    tinex  = s3_tlow || (tq_x81 != s3_tn);
    pq_up  = {2'd0, s3_pq} + {15'd0, pinex};
    tq_up  = {2'd0, s3_tq} + {15'd0, tinex};
    q_data.kind      = s3_kind;
    q_data.v1        = s3_v1;
    q_data.v2        = s3_v2;
    q_data.pan_f     = s3_pneg ? $signed(16'd0 - pq_up) : $signed({2'd0, s3_pq});
    q_data.pan_inex  = pinex;
    q_data.tilt_f    = s3_tneg ? $signed(16'd0 - tq_up) : $signed({2'd0, s3_tq});
    q_data.tilt_inex = tinex;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= take;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind <= kind_in;
      s1_v1   <= first_value;
      s1_v2   <= second_value;
      s1_dx   <= dx_in;
      s1_dy   <= dy_in;
    end
    if (adv2) begin
      s2_kind <= s1_kind;
      s2_v1   <= s1_v1;
      s2_v2   <= s1_v2;
      s2_pneg <= s1_dx[16];
      s2_tneg <= s1_dy[16];
      s2_pmag <= pprod[22:0];
      s2_tmag <= tprod[22:0];
    end
    if (adv3) begin
      s3_kind <= s2_kind;
      s3_v1   <= s2_v1;
      s3_v2   <= s2_v2;
      s3_pneg <= s2_pneg;
      s3_tneg <= s2_tneg;
      s3_plow <= |s2_pmag[5:0];
      s3_tlow <= |s2_tmag[1:0];
      s3_pn   <= s2_pmag[22:6];
      s3_tn   <= s2_tmag[22:2];
      s3_pq   <= pq_prod[33:20];
      s3_tq   <= tq_prod[40:27];
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && q_full) |=> (s3_valid && $stable(s3_pq) && $stable(s3_kind)))
    else $error("front end dropped a stalled entry");

  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv2) |=> (s1_valid && $stable(s1_dx)))
    else $error("stage one overwritten while stalled");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s3_valid) |=> s3_valid)
    else $error("stage two did not advance into an empty stage three");

endmodule

[rtl/pts_queue.sv]
// Short queue of classified work between the front and back ends.
module pts_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pts_pkg::entry_t din,
  output logic            full,
  input  logic            pop,
  output pts_pkg::entry_t dout,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pts_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count missed a pop");

endmodule

[rtl/pts_back.sv]
// Back end: axis state, tracking update and byte sequencer with output register.
module pts_back (
  input  logic            clk,
  input  logic            rst,
  input  pts_pkg::cfg_t   cfg,
  input  pts_pkg::entry_t q_dout,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output logic            port,
  output logic [7:0]      out_byte,
  output logic            last_byte
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t         st;
  pts_pkg::kind_t kind_q;
  logic [15:0]    v1_q, v2_q;
  logic [15:0]    pan_pos, tilt_pos;
  logic           tracking;
  logic [3:0]     idx, total;
  logic           out_valid;

  logic           can_load;
  logic [15:0]    pan_next, tilt_next;
  logic [3:0]     slen, ack_idx;
  logic           byte_port;
  logic [7:0]     byte_val, servo_val, op, ch, ch1;

  function automatic logic [15:0] track_axis(input logic [15:0] pos,
                                             input logic signed [15:0] f,
                                             input logic inex,
                                             input logic [15:0] lo,
                                             input logic [15:0] hi);
    logic signed [18:0] a;
    logic [15:0]        r;
    a = $signed({3'd0, pos}) + $signed({{3{f[15]}}, f});
    if (a < 0) a = a + $signed({18'd0, inex});
    if (a < $signed({3'd0, lo}))      r = lo;
    else if (a > $signed({3'd0, hi})) r = hi;
    else                              r = a[15:0];
    return r;
  endfunction

  function automatic logic [3:0] servo_len(input pts_pkg::kind_t k);
    logic [3:0] n;
    unique case (k)
      pts_pkg::KIND_POS, pts_pkg::KIND_EVENT:   n = 4'd7;
      pts_pkg::KIND_SPEED, pts_pkg::KIND_ACCEL: n = 4'd8;
      pts_pkg::KIND_QUERY:                      n = 4'd4;
      default:                                  n = 4'd0;
    endcase
    return n;
  endfunction

  assign empty     = !out_valid;
  assign can_load  = !out_valid || pop;
  assign q_pop     = (st == ST_IDLE) && !q_empty;
  assign pan_next  = track_axis(pan_pos, q_dout.pan_f, q_dout.pan_inex,
                                cfg.pan_min, cfg.pan_max);
  assign tilt_next = track_axis(tilt_pos, q_dout.tilt_f, q_dout.tilt_inex,
                                cfg.tilt_min, cfg.tilt_max);

  always_comb begin
    slen    = servo_len(kind_q);
    ack_idx = idx - slen;
    ch      = {1'b0, cfg.first_channel};
    ch1     = {1'b0, cfg.first_channel + 7'd1};
    op      = (kind_q == pts_pkg::KIND_SPEED) ? pts_pkg::OP_SPEED : pts_pkg::OP_ACCEL;
    unique case (kind_q)
      pts_pkg::KIND_POS, pts_pkg::KIND_EVENT: begin
        unique case (idx[2:0])
          3'd0:    servo_val = pts_pkg::OP_MULTI;
          3'd1:    servo_val = pts_pkg::MULTI_COUNT;
          3'd2:    servo_val = ch;
          3'd3:    servo_val = {1'b0, pan_pos[6:0]};
          3'd4:    servo_val = {1'b0, pan_pos[13:7]};
          3'd5:    servo_val = {1'b0, tilt_pos[6:0]};
          default: servo_val = {1'b0, tilt_pos[13:7]};
        endcase
      end
      pts_pkg::KIND_SPEED, pts_pkg::KIND_ACCEL: begin
        unique case (idx[2:0])
          3'd0:    servo_val = op;
          3'd1:    servo_val = ch;
          3'd2:    servo_val = {1'b0, v1_q[6:0]};
          3'd3:    servo_val = {1'b0, v1_q[13:7]};
          3'd4:    servo_val = op;
          3'd5:    servo_val = ch1;
          3'd6:    servo_val = {1'b0, v2_q[6:0]};
          default: servo_val = {1'b0, v2_q[13:7]};
        endcase
      end
      pts_pkg::KIND_QUERY: begin
        unique case (idx[1:0])
          2'd0:    servo_val = pts_pkg::OP_QUERY;
          2'd1:    servo_val = ch;
          2'd2:    servo_val = pts_pkg::OP_QUERY;
          default: servo_val = ch1;
        endcase
      end
      default: servo_val = 8'd0;
    endcase
    if (idx < slen) begin
      byte_port = pts_pkg::PORT_SERVO;
      byte_val  = servo_val;
    end else begin
      byte_port = pts_pkg::PORT_HOST;
      byte_val  = pts_pkg::ack_byte(ack_idx[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
      tracking  <= 1'b0;
      pan_pos   <= pts_pkg::POS_RESET;
      tilt_pos  <= pts_pkg::POS_RESET;
      idx       <= '0;
    end else begin
      if (st == ST_SEND && can_load) out_valid <= 1'b1;
      else if (pop)                  out_valid <= 1'b0;
      unique case (st)
        ST_IDLE: begin
          if (!q_empty) begin
            kind_q <= q_dout.kind;
            v1_q   <= q_dout.v1;
            v2_q   <= q_dout.v2;
            idx    <= '0;
            unique case (q_dout.kind)
              pts_pkg::KIND_POS:    total <= 4'd14;
              pts_pkg::KIND_SPEED,
              pts_pkg::KIND_ACCEL:  total <= 4'd15;
              pts_pkg::KIND_QUERY:  total <= 4'd11;
              default:              total <= 4'd7;
            endcase
            if (q_dout.kind == pts_pkg::KIND_POS) begin
              pan_pos  <= q_dout.v1;
              tilt_pos <= q_dout.v2;
            end
            if (q_dout.kind == pts_pkg::KIND_TOGGLE) tracking <= !tracking;
            if (q_dout.kind == pts_pkg::KIND_EVENT && tracking) begin
              pan_pos  <= pan_next;
              tilt_pos <= tilt_next;
            end
            if (!(q_dout.kind == pts_pkg::KIND_EVENT && !tracking)) st <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (can_load) begin
            port      <= byte_port;
            out_byte  <= byte_val;
            last_byte <= (idx == total - 4'd1);
            idx       <= idx + 4'd1;
            if (idx == total - 4'd1) st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  a_send_fills: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SEND) |=> out_valid)
    else $error("sequencer state without a byte in the output register");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SEND) |-> (idx < total))
    else $error("byte index past frame length");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SEND) |=> ($stable(pan_pos) && $stable(tilt_pos)))
    else $error("axis position changed while a frame is going out");

endmodule

[rtl/pan_tilt_servo_tracker.sv]
// Top level of the pan/tilt servo tracker: config registers and block wiring.
// Input channel: push/full. A beat is either a host command (func 0) or a
// target coordinate event (func 1). Result channel: empty/pop; each beat out
// is one byte with its destination (port 0 servo link, port 1 host) and
// last_byte set on the final byte an input causes.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready; write only while no work is in flight.
// Flow: the first byte of an item reaches the result ports through the
// front stages, the queue, the back end's load and the output register.
// The front end takes one beat per cycle until its three stages and the
// queue fill; the back end takes an item only after the last byte of the
// one before and sends 7 to 15 bytes; an event with tracking off sends none.
// Reset: positions 6000, tracking off, limits, center and channel to their
// defaults; queue and output register empty.
// When pop stays low the output register holds its byte, the back end
// stops, the queue and the front stages fill and full then rises.
module pan_tilt_servo_tracker #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               func,
  input  logic [7:0]         command_code,
  input  logic [15:0]        first_value,
  input  logic [15:0]        second_value,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  output logic               empty,
  input  logic               pop,
  output logic               port,
  output logic [7:0]         out_byte,
  output logic               last_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  pts_pkg::cfg_t   cfg;
  pts_pkg::entry_t q_din, q_dout;
  logic            q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_min       <= pts_pkg::PAN_MIN_RESET;
      cfg.pan_max       <= pts_pkg::PAN_MAX_RESET;
      cfg.tilt_min      <= pts_pkg::TILT_MIN_RESET;
      cfg.tilt_max      <= pts_pkg::TILT_MAX_RESET;
      cfg.center_x      <= pts_pkg::CENTER_X_RESET;
      cfg.center_y      <= pts_pkg::CENTER_Y_RESET;
      cfg.first_channel <= pts_pkg::CHANNEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pts_pkg::REG_PAN_MIN:       cfg.pan_min       <= cfg_data;
        pts_pkg::REG_PAN_MAX:       cfg.pan_max       <= cfg_data;
        pts_pkg::REG_TILT_MIN:      cfg.tilt_min      <= cfg_data;
        pts_pkg::REG_TILT_MAX:      cfg.tilt_max      <= cfg_data;
        pts_pkg::REG_CENTER_X:      cfg.center_x      <= cfg_data[11:0];
        pts_pkg::REG_CENTER_Y:      cfg.center_y      <= cfg_data[11:0];
        pts_pkg::REG_FIRST_CHANNEL: cfg.first_channel <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  pts_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .push         (push),
    .full         (full),
    .func         (func),
    .command_code (command_code),
    .first_value  (first_value),
    .second_value (second_value),
    .target_x     (target_x),
    .target_y     (target_y),
    .q_push       (q_push),
    .q_data       (q_din),
    .q_full       (q_full)
  );

  pts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  pts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_dout    (q_dout),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .port      (port),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule
